[src/spr_pkg.sv]
// Package for the stacked priority relocation state block.
// Shared types, codes and defaults; no dependencies.
package spr_pkg;

   localparam int STACKS_DEF    = 16;
   localparam int TIERS_DEF     = 64;
   localparam int PRIO_BITS_DEF = 8;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_RELOC = 2'd1,
      KIND_RETR  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_EMPTY  = 3'd1,
      STAT_FULL   = 3'd2,
      STAT_NORETR = 3'd3,
      STAT_INDEX  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_STACKS = 2'd0,
      CSR_TIERS  = 2'd1,
      CSR_MAXPRI = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_POP,
      BK_POPLD,
      BK_SIFT,
      BK_PUSH,
      BK_REPORT
   } back_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  src;
      logic [3:0]  dst;
      logic [7:0]  prio;
      logic [15:0] ts;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

[src/stacked_priority_relocation_state.sv]
// Stacked priority relocation state: front queue plus bay engine.
// Rejected items and queries only check and report; a pop adds pop and pop-load, a
// push adds push, each then sifting up to STACKS-1 sorted-list positions unless the
// top is bad; relocate both. One item in the engine at a time; two more may queue.
// Synchronous reset and any register write clear the bay; slot memory needs
// no clearing pass. Results are strobed for one cycle by rsp_valid.
module stacked_priority_relocation_state import spr_pkg::*; #(
   parameter int STACKS    = STACKS_DEF,
   parameter int TIERS     = TIERS_DEF,
   parameter int PRIO_BITS = PRIO_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_source_stack,
   input  logic [3:0]  req_dest_stack,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_time_stamp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_moved_priority,
   output logic [3:0]  rsp_first_stack,
   output logic [8:0]  rsp_first_min_priority,
   output logic        rsp_retrievable,
   output logic [10:0] rsp_bad_count,
   output logic [10:0] rsp_block_count,
   output logic [6:0]  rsp_queried_height,
   output logic [8:0]  rsp_queried_top_priority,
   output logic [15:0] rsp_queried_last_time
);

   queue_out_type q_out;
   logic          q_deq;

   spr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_source_stack (req_source_stack),
      .req_dest_stack   (req_dest_stack),
      .req_priority_req (req_priority_req),
      .req_time_stamp   (req_time_stamp),
      .q_out            (q_out),
      .q_deq            (q_deq)
   );

   spr_back #(.STACKS(STACKS), .TIERS(TIERS), .PRIO_BITS(PRIO_BITS)) u_back (
      .clock                    (clock),
      .reset                    (reset),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .q_out                    (q_out),
      .q_deq                    (q_deq),
      .rsp_valid                (rsp_valid),
      .rsp_status               (rsp_status),
      .rsp_moved_priority       (rsp_moved_priority),
      .rsp_first_stack          (rsp_first_stack),
      .rsp_first_min_priority   (rsp_first_min_priority),
      .rsp_retrievable          (rsp_retrievable),
      .rsp_bad_count            (rsp_bad_count),
      .rsp_block_count          (rsp_block_count),
      .rsp_queried_height       (rsp_queried_height),
      .rsp_queried_top_priority (rsp_queried_top_priority),
      .rsp_queried_last_time    (rsp_queried_last_time)
   );

endmodule

[src/spr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/spr_front.sv]
// Front end: takes request transfers, decodes the kind, queues two items.
// Depends on spr_pkg.
module spr_front import spr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_kind,
   input  logic [3:0]    req_source_stack,
   input  logic [3:0]    req_dest_stack,
   input  logic [7:0]    req_priority_req,
   input  logic [15:0]   req_time_stamp,
   output queue_out_type q_out,
   input  logic          q_deq
);

   item_type   entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_in;

   always_comb begin
      item_in.src  = req_source_stack;
      item_in.dst  = req_dest_stack;
      item_in.prio = req_priority_req;
      item_in.ts   = req_time_stamp;
      item_in.kind = kind_type'(req_kind);
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = (q_deq && q_out.valid) ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_deq && q_out.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= item_in;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = entry_ff[rptr_ff];

endmodule

[src/spr_back.sv]
// Back end: checks and executes queued items on the bay, keeps the sorted list.
// Depends on spr_pkg and spr_ram.
module spr_back import spr_pkg::*; #(
   parameter int STACKS    = STACKS_DEF,
   parameter int TIERS     = TIERS_DEF,
   parameter int PRIO_BITS = PRIO_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata,
   input  queue_out_type q_out,
   output logic          q_deq,
   output logic          rsp_valid,
   output logic [2:0]    rsp_status,
   output logic [7:0]    rsp_moved_priority,
   output logic [3:0]    rsp_first_stack,
   output logic [8:0]    rsp_first_min_priority,
   output logic          rsp_retrievable,
   output logic [10:0]   rsp_bad_count,
   output logic [10:0]   rsp_block_count,
   output logic [6:0]    rsp_queried_height,
   output logic [8:0]    rsp_queried_top_priority,
   output logic [15:0]   rsp_queried_last_time
);

   localparam int SW  = $clog2(STACKS);
   localparam int TW  = $clog2(TIERS + 1);
   localparam int PW  = PRIO_BITS;
   localparam int BW  = $clog2(TIERS);
   localparam int CW  = $clog2(STACKS * TIERS + 1);
   localparam int DEP = STACKS * TIERS;
   localparam int AW  = $clog2(DEP);
   localparam int DW  = 2 * PW + BW;

   back_state_type state_ff, state_in;

   logic [4:0]    stacks_ff;
   logic [6:0]    tiers_ff;
   logic [7:0]    maxpri_ff;
   logic          clear;

   logic [TW-1:0] height_ff [STACKS];
   logic [PW-1:0] tprio_ff  [STACKS];
   logic [PW-1:0] tmin_ff   [STACKS];
   logic [BW-1:0] tbad_ff   [STACKS];
   logic [15:0]   time_ff   [STACKS];
   logic [SW-1:0] order_ff  [STACKS];
   logic [SW-1:0] rank_ff   [STACKS];
   logic [CW-1:0] bad_total_ff, block_total_ff;

   item_type      item_ff;
   status_type    status_ff;
   logic [PW-1:0] moved_ff;
   logic [SW-1:0] cur_ff, idx_ff, pushdst_ff;
   logic [PW-1:0] pushp_ff;
   logic          push_pend_ff, wasbad_ff, dir_right_ff;

   logic [PW-1:0] limit;
   logic [PW:0]   sent;
   logic [7:0]    ns;
   logic [8:0]    nt;
   logic [SW-1:0] src, dst, first, nb, idx_up, idx_dn;
   logic          src_bad, dst_bad;
   logic [PW:0]   min_cur, min_nb;
   logic          sift_move;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata, ram_rdata;

   logic [TW-1:0] pop_h, push_h;
   logic [PW:0]   below_min;
   logic [BW-1:0] below_bad, new_bad;
   logic [PW-1:0] new_min;

   assign clear = csr_we && (csr_index == CSR_STACKS || csr_index == CSR_TIERS ||
                             csr_index == CSR_MAXPRI);

   assign limit = PW'(maxpri_ff);
   assign sent  = {1'b0, limit} + (PW+1)'(1);

   always_comb begin
      if (stacks_ff == 5'd0) ns = 8'd1;
      else if (8'(stacks_ff) > 8'(STACKS)) ns = 8'(STACKS);
      else ns = 8'(stacks_ff);
      if (tiers_ff == 7'd0) nt = 9'd1;
      else if (9'(tiers_ff) > 9'(TIERS)) nt = 9'(TIERS);
      else nt = 9'(tiers_ff);
   end

   assign src     = SW'(item_ff.src);
   assign dst     = SW'(item_ff.dst);
   assign first   = order_ff[0];
   assign src_bad = 8'(item_ff.src) >= ns;
   assign dst_bad = 8'(item_ff.dst) >= ns;

   assign idx_up  = idx_ff + SW'(1);
   assign idx_dn  = idx_ff - SW'(1);
   assign nb      = dir_right_ff ? order_ff[idx_up] : order_ff[idx_dn];
   assign min_cur = (height_ff[cur_ff] == '0) ? sent : {1'b0, tmin_ff[cur_ff]};
   assign min_nb  = (height_ff[nb] == '0) ? sent : {1'b0, tmin_ff[nb]};
   assign sift_move = dir_right_ff ?
                      (idx_ff != SW'(STACKS - 1) && min_cur > min_nb) :
                      (idx_ff != '0 && min_cur < min_nb);

   // pop: new top lives at tier pop_h, i.e. slot pop_h-1
   assign pop_h     = height_ff[cur_ff] - TW'(1);
   assign ram_raddr = AW'(cur_ff) * AW'(TIERS) + AW'(pop_h) - AW'(1);

   assign push_h    = height_ff[pushdst_ff] + TW'(1);
   assign below_min = (height_ff[pushdst_ff] == '0) ? sent : {1'b0, tmin_ff[pushdst_ff]};
   assign below_bad = (height_ff[pushdst_ff] == '0) ? '0 : tbad_ff[pushdst_ff];
   always_comb begin
      if ({1'b0, pushp_ff} <= below_min) begin
         new_min = pushp_ff;
         new_bad = '0;
      end else begin
         new_min = PW'(below_min);
         new_bad = below_bad + BW'(1);
      end
   end
   assign ram_we    = (state_ff == BK_PUSH);
   assign ram_waddr = AW'(pushdst_ff) * AW'(TIERS) + AW'(push_h) - AW'(1);
   assign ram_wdata = {pushp_ff, new_min, new_bad};

   spr_ram #(.WIDTH(DW), .DEPTH(DEP)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign q_deq = (state_ff == BK_IDLE) && q_out.valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (q_out.valid) state_in = BK_CHECK;
         BK_CHECK: begin
            state_in = BK_REPORT;
            case (item_ff.kind)
               KIND_LOAD:
                  if (!src_bad && 9'(height_ff[src]) < nt) state_in = BK_PUSH;
               KIND_RELOC:
                  if (!src_bad && !dst_bad && height_ff[src] != '0 &&
                      (dst == src || 9'(height_ff[dst]) < nt)) state_in = BK_POP;
               KIND_RETR:
                  if (block_total_ff != '0 && height_ff[first] != '0 &&
                      tbad_ff[first] == '0) state_in = BK_POP;
               default: state_in = BK_REPORT;
            endcase
         end
         BK_POP:    state_in = BK_POPLD;
         BK_POPLD:  if (wasbad_ff) state_in = push_pend_ff ? BK_PUSH : BK_REPORT;
                    else state_in = BK_SIFT;
         BK_SIFT:   if (!sift_move) state_in = push_pend_ff ? BK_PUSH : BK_REPORT;
         BK_PUSH:   state_in = (new_bad != '0) ? BK_REPORT : BK_SIFT;
         BK_REPORT: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff       <= BK_IDLE;
         bad_total_ff   <= '0;
         block_total_ff <= '0;
         rsp_valid      <= 1'b0;
         for (int i = 0; i < STACKS; i++) begin
            height_ff[i] <= '0;
            time_ff[i]   <= '0;
            order_ff[i]  <= SW'(i);
            rank_ff[i]   <= SW'(i);
         end
         if (reset) begin
            stacks_ff <= 5'd16;
            tiers_ff  <= 7'd64;
            maxpri_ff <= 8'd255;
         end else begin
            case (csr_index)
               CSR_STACKS: stacks_ff <= csr_wdata[4:0];
               CSR_TIERS:  tiers_ff  <= csr_wdata[6:0];
               CSR_MAXPRI: maxpri_ff <= csr_wdata;
               default: ;
            endcase
         end
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == BK_REPORT);
         case (state_ff)
            BK_IDLE: begin
               item_ff      <= q_out.item;
               status_ff    <= STAT_OK;
               moved_ff     <= '0;
               push_pend_ff <= 1'b0;
            end
            BK_CHECK: begin
               case (item_ff.kind)
                  KIND_LOAD: begin
                     pushdst_ff <= src;
                     pushp_ff   <= (16'(item_ff.prio) > 16'(limit)) ? limit :
                                   PW'(item_ff.prio);
                     if (src_bad) status_ff <= STAT_INDEX;
                     else if (9'(height_ff[src]) >= nt) status_ff <= STAT_FULL;
                     else block_total_ff <= block_total_ff + CW'(1);
                  end
                  KIND_RELOC: begin
                     cur_ff       <= src;
                     pushdst_ff   <= dst;
                     pushp_ff     <= tprio_ff[src];
                     push_pend_ff <= 1'b1;
                     if (src_bad || dst_bad) status_ff <= STAT_INDEX;
                     else if (height_ff[src] == '0) status_ff <= STAT_EMPTY;
                     else if (dst != src && 9'(height_ff[dst]) >= nt)
                        status_ff <= STAT_FULL;
                     else moved_ff <= tprio_ff[src];
                  end
                  KIND_RETR: begin
                     cur_ff <= first;
                     if (block_total_ff == '0 || height_ff[first] == '0 ||
                         tbad_ff[first] != '0) begin
                        status_ff <= STAT_NORETR;
                     end else begin
                        moved_ff       <= tprio_ff[first];
                        block_total_ff <= block_total_ff - CW'(1);
                     end
                  end
                  default: begin
                     if (src_bad) status_ff <= STAT_INDEX;
                  end
               endcase
            end
            BK_POP: begin
               height_ff[cur_ff] <= pop_h;
               time_ff[cur_ff]   <= item_ff.ts;
               wasbad_ff         <= (tbad_ff[cur_ff] != '0);
               if (tbad_ff[cur_ff] != '0) bad_total_ff <= bad_total_ff - CW'(1);
            end
            BK_POPLD: begin
               {tprio_ff[cur_ff], tmin_ff[cur_ff], tbad_ff[cur_ff]} <= ram_rdata;
               idx_ff       <= rank_ff[cur_ff];
               dir_right_ff <= 1'b1;
            end
            BK_SIFT: begin
               if (sift_move) begin
                  order_ff[idx_ff] <= nb;
                  rank_ff[nb]      <= idx_ff;
                  idx_ff           <= dir_right_ff ? idx_up : idx_dn;
               end else begin
                  order_ff[idx_ff] <= cur_ff;
                  rank_ff[cur_ff]  <= idx_ff;
               end
            end
            BK_PUSH: begin
               push_pend_ff          <= 1'b0;
               height_ff[pushdst_ff] <= push_h;
               tprio_ff[pushdst_ff]  <= pushp_ff;
               tmin_ff[pushdst_ff]   <= new_min;
               tbad_ff[pushdst_ff]   <= new_bad;
               time_ff[pushdst_ff]   <= item_ff.ts;
               cur_ff                <= pushdst_ff;
               idx_ff                <= rank_ff[pushdst_ff];
               dir_right_ff          <= 1'b0;
               if (new_bad != '0) bad_total_ff <= bad_total_ff + CW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_REPORT) begin
         rsp_status             <= status_ff;
         rsp_moved_priority     <= 8'(moved_ff);
         rsp_first_stack        <= 4'(first);
         rsp_first_min_priority <= (height_ff[first] == '0) ? 9'(sent) :
                                   9'(tmin_ff[first]);
         rsp_retrievable        <= (block_total_ff != '0) &&
                                   (height_ff[first] == '0 || tbad_ff[first] == '0);
         rsp_bad_count          <= 11'(bad_total_ff);
         rsp_block_count        <= 11'(block_total_ff);
         if (src_bad) begin
            rsp_queried_height       <= 7'd0;
            rsp_queried_top_priority <= 9'(sent);
            rsp_queried_last_time    <= 16'd0;
         end else begin
            rsp_queried_height       <= 7'(height_ff[src]);
            rsp_queried_top_priority <= (height_ff[src] == '0) ? 9'(sent) :
                                        9'(tprio_ff[src]);
            rsp_queried_last_time    <= time_ff[src];
         end
      end
   end

endmodule

[tb/tb_stacked_priority_relocation_state.sv]
// Testbench for stacked_priority_relocation_state: directed and random bay operations
// checked against a behavioral bay model held in a scoreboard class.
// Depends on spr_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_stacked_priority_relocation_state;
   import spr_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [7:0]  moved;
      logic [3:0]  first;
      logic [8:0]  first_min;
      logic        retr;
      logic [10:0] bad;
      logic [10:0] blocks;
      logic [6:0]  qheight;
      logic [8:0]  qtop;
      logic [15:0] qtime;
   } bay_result_type;

   class bay_scoreboard;
      int unsigned stack_limit, n_tiers, prio_max;
      int unsigned prio[16][65];
      int unsigned rmin[16][65];
      int unsigned badn[16][65];
      int unsigned height[16];
      int unsigned order[16];
      int unsigned rank[16];
      int unsigned last_ts[16];
      int unsigned bad_total, block_total;
      bay_result_type pending[$];
      int errors;

      function new();
         errors = 0;
         stack_limit = 16;
         n_tiers = 64;
         prio_max = 255;
         clear_bay();
      endfunction

      function void clear_bay();
         for (int s = 0; s < 16; s++) begin
            prio[s][0] = prio_max + 1;
            rmin[s][0] = prio_max + 1;
            badn[s][0] = 0;
            height[s] = 0;
            order[s] = s;
            rank[s] = s;
            last_ts[s] = 0;
         end
         bad_total = 0;
         block_total = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] val);
         case (idx)
            CSR_STACKS: begin
               stack_limit = val[4:0];
               if (stack_limit < 1) stack_limit = 1;
               if (stack_limit > 16) stack_limit = 16;
            end
            CSR_TIERS: begin
               n_tiers = val[6:0];
               if (n_tiers < 1) n_tiers = 1;
               if (n_tiers > 64) n_tiers = 64;
            end
            CSR_MAXPRI: prio_max = val;
            default: return;
         endcase
         clear_bay();
      endfunction

      function int unsigned top_min(int unsigned s);
         return rmin[s][height[s]];
      endfunction

      function void move_up(int unsigned s);
         int unsigned i;
         i = rank[s];
         while (i > 0 && top_min(s) < top_min(order[i-1])) begin
            order[i] = order[i-1];
            rank[order[i]] = i;
            i--;
         end
         order[i] = s;
         rank[s] = i;
      endfunction

      function void move_down(int unsigned s);
         int unsigned i;
         i = rank[s];
         while (i + 1 < 16 && top_min(s) > top_min(order[i+1])) begin
            order[i] = order[i+1];
            rank[order[i]] = i;
            i++;
         end
         order[i] = s;
         rank[s] = i;
      endfunction

      function void push(int unsigned d, int unsigned p, int unsigned ts);
         int unsigned t;
         height[d]++;
         t = height[d];
         prio[d][t] = p;
         if (p <= rmin[d][t-1]) begin
            rmin[d][t] = p;
            badn[d][t] = 0;
         end else begin
            rmin[d][t] = rmin[d][t-1];
            badn[d][t] = badn[d][t-1] + 1;
         end
         if (badn[d][t] > 0) bad_total++;
         else move_up(d);
         last_ts[d] = ts;
      endfunction

      function void pop(int unsigned s, int unsigned ts);
         int unsigned t;
         t = height[s];
         height[s] = t - 1;
         if (badn[s][t] > 0) bad_total--;
         else move_down(s);
         last_ts[s] = ts;
      endfunction

      function void note_item(item_type it);
         bay_result_type r;
         int unsigned src, dst, p, f;
         src = it.src;
         dst = it.dst;
         p = it.prio;
         r = '0;
         r.status = STAT_OK;
         case (it.kind)
            KIND_LOAD: begin
               if (src >= stack_limit) r.status = STAT_INDEX;
               else if (height[src] >= n_tiers) r.status = STAT_FULL;
               else begin
                  if (p > prio_max) p = prio_max;
                  push(src, p, it.ts);
                  block_total++;
               end
            end
            KIND_RELOC: begin
               if (src >= stack_limit || dst >= stack_limit) r.status = STAT_INDEX;
               else if (height[src] == 0) r.status = STAT_EMPTY;
               else if (dst != src && height[dst] >= n_tiers) r.status = STAT_FULL;
               else begin
                  r.moved = 8'(prio[src][height[src]]);
                  pop(src, it.ts);
                  push(dst, r.moved, it.ts);
               end
            end
            KIND_RETR: begin
               f = order[0];
               if (block_total == 0 || height[f] == 0 || badn[f][height[f]] != 0)
                  r.status = STAT_NORETR;
               else begin
                  r.moved = 8'(prio[f][height[f]]);
                  block_total--;
                  height[f]--;
                  move_down(f);
                  last_ts[f] = it.ts;
               end
            end
            default: if (src >= stack_limit) r.status = STAT_INDEX;
         endcase
         f = order[0];
         r.first = 4'(f);
         r.first_min = 9'(top_min(f));
         r.retr = block_total > 0 && badn[f][height[f]] == 0;
         r.bad = 11'(bad_total);
         r.blocks = 11'(block_total);
         if (src < stack_limit) begin
            r.qheight = 7'(height[src]);
            r.qtop = 9'(prio[src][height[src]]);
            r.qtime = 16'(last_ts[src]);
         end else begin
            r.qheight = 0;
            r.qtop = 9'(prio_max + 1);
            r.qtime = 0;
         end
         pending.push_back(r);
      endfunction

      function void check_result(bay_result_type got);
         bay_result_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result %p", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("ERROR: mismatch\n  exp %p\n  got %p", exp, got);
         end
      endfunction
   endclass

   logic        clock, reset, start, busy;
   logic [1:0]  req_kind;
   logic [3:0]  req_source_stack, req_dest_stack;
   logic [7:0]  req_priority_req;
   logic [15:0] req_time_stamp;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_moved_priority;
   logic [3:0]  rsp_first_stack;
   logic [8:0]  rsp_first_min_priority;
   logic        rsp_retrievable;
   logic [10:0] rsp_bad_count, rsp_block_count;
   logic [6:0]  rsp_queried_height;
   logic [8:0]  rsp_queried_top_priority;
   logic [15:0] rsp_queried_last_time;

   stacked_priority_relocation_state dut (.*);

   bay_scoreboard bay;
   bit quiet_sender;
   int unsigned step_ts;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         bay.check_result({status_type'(rsp_status), rsp_moved_priority, rsp_first_stack,
            rsp_first_min_priority, rsp_retrievable, rsp_bad_count, rsp_block_count,
            rsp_queried_height, rsp_queried_top_priority, rsp_queried_last_time});
   end

   // start stays high between back-to-back transfers; idling lowers it
   task automatic send_item(kind_type k, int src, int dst, int p);
      item_type it;
      if (!quiet_sender && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      it.kind = k;
      it.src = 4'(src);
      it.dst = 4'(dst);
      it.prio = 8'(p);
      it.ts = (step_ts % 5 == 0) ? 16'($urandom) : 16'(step_ts);
      step_ts++;
      start <= 1'b1;
      req_kind <= it.kind;
      req_source_stack <= it.src;
      req_dest_stack <= it.dst;
      req_priority_req <= it.prio;
      req_time_stamp <= it.ts;
      do @(posedge clock); while (busy);
      bay.note_item(it);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (bay.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 8'(val);
      @(posedge clock);
      bay.write_reg(idx, 8'(val));
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int unsigned ns;
      int r;
      ns = bay.stack_limit;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (i > count * 3 / 4) quiet_sender = 1'b1;
         if (r < 40)
            send_item(KIND_LOAD, $urandom_range(ns - 1), $urandom, $urandom);
         else if (r < 65)
            send_item(KIND_RELOC, $urandom_range(ns - 1), $urandom_range(ns - 1), $urandom);
         else if (r < 85)
            send_item(KIND_RETR, $urandom, $urandom, $urandom);
         else if (r < 93)
            send_item(KIND_QUERY, $urandom_range(ns - 1), $urandom, $urandom);
         else
            send_item(kind_type'($urandom_range(3)), $urandom, $urandom, $urandom);
      end
      quiet_sender = 1'b0;
   endtask

   initial begin
      bay = new();
      quiet_sender = 1'b0;
      step_ts = 1;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_LOAD;
      req_source_stack = '0;
      req_dest_stack = '0;
      req_priority_req = '0;
      req_time_stamp = '0;
      csr_we = 1'b0;
      csr_index = CSR_STACKS;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(KIND_RETR, 0, 0, 0);
      send_item(KIND_RELOC, 3, 4, 0);
      send_item(KIND_LOAD, 2, 0, 255);
      send_item(KIND_LOAD, 2, 0, 0);
      send_item(KIND_LOAD, 2, 0, 100);
      send_item(KIND_LOAD, 5, 0, 0);
      send_item(KIND_LOAD, 15, 0, 170);
      send_item(KIND_QUERY, 2, 0, 0);
      send_item(KIND_RETR, 0, 0, 0);
      send_item(KIND_RELOC, 2, 2, 0);
      send_item(KIND_RELOC, 2, 15, 0);
      send_item(KIND_RETR, 0, 0, 0);
      send_item(KIND_RETR, 0, 0, 0);
      send_item(KIND_QUERY, 15, 0, 0);

      write_reg(CSR_MAXPRI, 7);
      write_reg(CSR_STACKS, 3);
      write_reg(CSR_TIERS, 2);
      send_item(KIND_LOAD, 3, 0, 1);
      send_item(KIND_LOAD, 0, 0, 200);
      send_item(KIND_LOAD, 0, 0, 3);
      send_item(KIND_LOAD, 0, 0, 1);
      send_item(KIND_LOAD, 1, 0, 5);
      send_item(KIND_RELOC, 1, 0, 0);
      send_item(KIND_RELOC, 0, 4, 0);
      send_item(KIND_QUERY, 12, 0, 0);
      random_phase(150);

      write_reg(CSR_STACKS, 0);
      write_reg(CSR_TIERS, 0);
      write_reg(CSR_MAXPRI, 0);
      random_phase(60);

      write_reg(CSR_STACKS, 31);
      write_reg(CSR_TIERS, 127);
      write_reg(CSR_MAXPRI, 255);
      random_phase(350);

      write_reg(CSR_STACKS, 5);
      write_reg(CSR_TIERS, 6);
      write_reg(CSR_MAXPRI, 15);
      random_phase(200);

      write_reg(CSR_STACKS, 16);
      write_reg(CSR_TIERS, 64);
      write_reg(CSR_MAXPRI, 254);
      random_phase(250);

      drain();
      if (bay.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
